### src/sorted_table_insert_assert.svh
// assertion macros for the sorted table insert block
// clocked on aclk, disabled while aresetn is low; no other dependencies
`ifndef SORTED_TABLE_INSERT_ASSERT_SVH
`define SORTED_TABLE_INSERT_ASSERT_SVH

// condition holds at every clock edge out of reset
`define STI_CHECK(label, cond) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("sorted table check failed");

// trigger in a cycle implies the outcome in the next cycle
`define STI_CHECK_NEXT(label, trig, outcome) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (outcome)) \
        else $error("sorted table sequence check failed");

`endif

### src/sti_pkg.sv
// shared types and constants for the sorted table insert block
// no dependencies; used by sti_cell and sorted_table_insert
package sti_pkg;

    localparam int TABLE_DEPTH_DEF = 16;
    localparam int KEY_BYTES_DEF   = 8;

    localparam int IN_KEY_W   = 64;
    localparam int IN_PAY_W   = 32;
    localparam int IN_IDX_W   = 4;
    localparam int OUT_CNT_W  = 5;
    localparam int STATUS_W   = 3;
    localparam int S_TDATA_W  = 104;
    localparam int M_TDATA_W  = 104;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_READ   = 1'b1
    } sti_cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED   = 3'd0,
        ST_FULL       = 3'd1,
        ST_EMPTY_KEY  = 3'd2,
        ST_READ_OK    = 3'd3,
        ST_SLOT_EMPTY = 3'd4
    } sti_status_t;

    // per-cell control from the top level and the lower neighbor
    typedef struct packed {
        logic ins_go;   // an insert is committed this cycle
        logic prev_gt;  // lower neighbor moves up, so this cell takes its entry
        logic prev_occ; // lower neighbor holds an entry
    } sti_cell_ctl_t;

endpackage

### src/sti_cell.sv
// one slot of the sorted table: holds key, payload and an occupied flag
// depends on sti_pkg for the cell control struct
module sti_cell #(
    parameter int KEY_W = 64,
    parameter int PAY_W = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  sti_pkg::sti_cell_ctl_t ctl,
    input  logic [KEY_W-1:0]      new_key,
    input  logic [PAY_W-1:0]      new_payload,
    input  logic [KEY_W-1:0]      prev_key,
    input  logic [PAY_W-1:0]      prev_payload,
    output logic                  occ_o,
    output logic                  gt_o,
    output logic [KEY_W-1:0]      key_o,
    output logic [PAY_W-1:0]      payload_o
);

    logic             occ_reg, occ_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [PAY_W-1:0] pay_reg, pay_next;

    // empty slots count as greater so the new entry lands in the first free slot
    assign gt_o = !occ_reg || (key_reg > new_key);

    always_comb begin
        occ_next = occ_reg;
        key_next = key_reg;
        pay_next = pay_reg;
        if (ctl.ins_go) begin
            if (ctl.prev_gt) begin
                // an empty neighbor below hands up an empty slot
                occ_next = ctl.prev_occ;
                key_next = prev_key;
                pay_next = prev_payload;
            end else if (gt_o) begin
                occ_next = 1'b1;
                key_next = new_key;
                pay_next = new_payload;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= 1'b0;
        end else begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
        pay_reg <= pay_next;
    end

    assign occ_o     = occ_reg;
    assign key_o     = key_reg;
    assign payload_o = pay_reg;

endmodule

### src/sorted_table_insert.sv
// sorted table insert top level: chain of compare-and-shift cells plus output register
// depends on sti_pkg, sti_cell and sorted_table_insert_assert.svh
//
// channel  dir  handshake          payload
// s_       in   s_tvalid/s_tready  s_tuser command, s_tdata key/payload/read_index
// m_       out  m_tvalid/m_tready  m_tuser status, m_tdata out_key/out_payload/entry_count
//
// one item per cycle while s_tready is high: every cell compares its key with the incoming
// key in parallel and takes the new entry or its lower neighbor's entry, or keeps its own
// the result is registered in the output register as the item is accepted
// synchronous active-low reset empties all slots at once and clears the count
// s_tready stays high while the output register is empty or being drained
`include "sorted_table_insert_assert.svh"

module sorted_table_insert #(
    parameter int TABLE_DEPTH = sti_pkg::TABLE_DEPTH_DEF,
    parameter int KEY_BYTES   = sti_pkg::KEY_BYTES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [63:0] key, [95:64] payload, [99:96] read_index, [103:100] zero
    input  logic [sti_pkg::S_TDATA_W-1:0] s_tdata,
    // [0] command
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [63:0] out_key, [95:64] out_payload, [100:96] entry_count, [103:101] zero
    output logic [sti_pkg::M_TDATA_W-1:0] m_tdata,
    // [2:0] status
    output logic [sti_pkg::STATUS_W-1:0]  m_tuser
);

    localparam int KEY_W = KEY_BYTES * 8;
    localparam int PAY_W = sti_pkg::IN_PAY_W;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    // input unpack; only the low KEY_BYTES bytes of the key take part
    logic                         in_accept;
    logic [KEY_W-1:0]             in_key;
    logic [PAY_W-1:0]             in_payload;
    logic [sti_pkg::IN_IDX_W-1:0] in_idx;
    sti_pkg::sti_cmd_t            in_cmd;

    assign in_accept  = s_tvalid && s_tready;
    assign in_key     = s_tdata[KEY_W-1:0];
    assign in_payload = s_tdata[sti_pkg::IN_KEY_W +: PAY_W];
    assign in_idx     = s_tdata[sti_pkg::IN_KEY_W + PAY_W +: sti_pkg::IN_IDX_W];
    assign in_cmd     = sti_pkg::sti_cmd_t'(s_tuser);

    // cell chain signals
    logic [TABLE_DEPTH-1:0] cell_occ;
    logic [TABLE_DEPTH-1:0] cell_gt;
    logic [KEY_W-1:0]       cell_key [TABLE_DEPTH];
    logic [PAY_W-1:0]       cell_pay [TABLE_DEPTH];

    logic             table_full;
    logic             key_empty;
    logic             ins_go;
    logic [CNT_W-1:0] count_reg, count_next;

    assign table_full = cell_occ[TABLE_DEPTH-1];
    assign key_empty  = (in_key[KEY_W-1 -: 8] == 8'd0);
    assign ins_go     = in_accept && (in_cmd == sti_pkg::CMD_INSERT)
                        && !table_full && !key_empty;

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
            sti_pkg::sti_cell_ctl_t ctl;
            logic [KEY_W-1:0]       nb_key;
            logic [PAY_W-1:0]       nb_pay;

            assign ctl.ins_go = ins_go;
            if (gi == 0) begin : g_first
                // bottom of the chain has no neighbor below
                assign ctl.prev_gt  = 1'b0;
                assign ctl.prev_occ = 1'b0;
                assign nb_key       = in_key;
                assign nb_pay       = in_payload;
            end else begin : g_rest
                assign ctl.prev_gt  = cell_gt[gi-1];
                assign ctl.prev_occ = cell_occ[gi-1];
                assign nb_key       = cell_key[gi-1];
                assign nb_pay       = cell_pay[gi-1];
            end

            sti_cell #(
                .KEY_W (KEY_W),
                .PAY_W (PAY_W)
            ) u_cell (
                .aclk         (aclk),
                .aresetn      (aresetn),
                .ctl          (ctl),
                .new_key      (in_key),
                .new_payload  (in_payload),
                .prev_key     (nb_key),
                .prev_payload (nb_pay),
                .occ_o        (cell_occ[gi]),
                .gt_o         (cell_gt[gi]),
                .key_o        (cell_key[gi]),
                .payload_o    (cell_pay[gi])
            );
        end
    endgenerate

    assign count_next = ins_go ? (count_reg + 1'b1) : count_reg;

    // read select: and-or mux over the cells at read_index
    logic             rd_hit;
    logic [KEY_W-1:0] rd_key;
    logic [PAY_W-1:0] rd_pay;

    assign rd_hit = ({{CNT_W{1'b0}}, in_idx} < {{sti_pkg::IN_IDX_W{1'b0}}, count_reg});

    always_comb begin
        rd_key = '0;
        rd_pay = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (32'(in_idx) == i) begin
                rd_key = rd_key | cell_key[i];
                rd_pay = rd_pay | cell_pay[i];
            end
        end
    end

    // result forming
    sti_pkg::sti_status_t             res_status;
    logic [KEY_W+sti_pkg::IN_KEY_W-1:0] res_key_wide;
    logic [sti_pkg::IN_KEY_W-1:0]      res_key;
    logic [PAY_W-1:0]                  res_pay;
    logic [CNT_W+sti_pkg::OUT_CNT_W-1:0] cnt_wide;

    always_comb begin
        res_status   = sti_pkg::ST_SLOT_EMPTY;
        res_key_wide = '0;
        res_pay      = '0;
        if (in_cmd == sti_pkg::CMD_INSERT) begin
            if (table_full) begin
                res_status = sti_pkg::ST_FULL;
            end else if (key_empty) begin
                res_status = sti_pkg::ST_EMPTY_KEY;
            end else begin
                res_status = sti_pkg::ST_INSERTED;
            end
        end else if (rd_hit) begin
            res_status   = sti_pkg::ST_READ_OK;
            res_key_wide = {{sti_pkg::IN_KEY_W{1'b0}}, rd_key};
            res_pay      = rd_pay;
        end
    end

    assign res_key  = res_key_wide[sti_pkg::IN_KEY_W-1:0];
    assign cnt_wide = {{sti_pkg::OUT_CNT_W{1'b0}}, count_next};

    // output register
    logic                             m_valid_reg, m_valid_next;
    sti_pkg::sti_status_t             m_status_reg;
    logic [sti_pkg::IN_KEY_W-1:0]     m_key_reg;
    logic [PAY_W-1:0]                 m_pay_reg;
    logic [sti_pkg::OUT_CNT_W-1:0]    m_cnt_reg;

    assign s_tready = !m_valid_reg || m_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (in_accept) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            count_reg   <= '0;
        end else begin
            m_valid_reg <= m_valid_next;
            count_reg   <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            m_status_reg <= res_status;
            m_key_reg    <= res_key;
            m_pay_reg    <= res_pay;
            m_cnt_reg    <= cnt_wide[sti_pkg::OUT_CNT_W-1:0];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {3'b000, m_cnt_reg, m_pay_reg, m_key_reg};

    // count always equals the number of occupied cells
    `STI_CHECK(a_cnt_matches_occ, CNT_W'($countones(cell_occ)) == count_reg)
    // occupied cells form an unbroken run from slot 0
    `STI_CHECK(a_occ_prefix, (cell_occ & (cell_occ + 1'b1)) == '0)
    // a committed insert grows the table by exactly one
    `STI_CHECK_NEXT(a_ins_grows, ins_go, count_reg == $past(count_reg) + 1'b1)

endmodule

### tb/sv/sorted_table_insert_tb.sv
// self-checking testbench for the sorted table insert block
// keeps a shadow copy of the sorted table and compares every result item
// depends on sti_pkg and sorted_table_insert
module sorted_table_insert_tb;
    import sti_pkg::*;

    localparam int DEPTH       = TABLE_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 8;

    // one expected result item
    typedef struct {
        sti_status_t status;
        logic [63:0] key;
        logic [31:0] payload;
        logic [4:0]  entries;
    } table_answer_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tuser  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]  m_tuser;

    // shadow of the table contents, updated as each item is accepted
    logic [63:0] shadow_keys [DEPTH];
    logic [31:0] shadow_pays [DEPTH];
    int          shadow_count = 0;

    table_answer_t answers_due [$];
    int            err_count     = 0;
    int            tx_idle_pct   = 0;
    int            rx_idle_pct   = 0;
    int            rx_hold_cycles = 0;
    bit            rx_hold       = 1'b0;
    int            cycles_run;

    sorted_table_insert dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // run limit, counted in clock cycles
    initial begin
        for (cycles_run = 0; cycles_run < CYCLE_LIMIT; cycles_run++) @(posedge aclk);
        $display("sorted_table_insert_tb failed");
        $finish;
    end

    // work out the answer to one accepted item and update the shadow table
    function automatic table_answer_t predict_table_item(input sti_cmd_t cmd,
                                                         input logic [63:0] key,
                                                         input logic [31:0] pay,
                                                         input logic [3:0] idx);
        table_answer_t ans;
        int pos;
        ans.key     = '0;
        ans.payload = '0;
        if (cmd == CMD_INSERT) begin
            // full is checked ahead of the empty key
            if (shadow_count >= DEPTH) begin
                ans.status = ST_FULL;
            end else if (key[63:56] == 8'h00) begin
                ans.status = ST_EMPTY_KEY;
            end else begin
                // new entry lands after every key less than or equal to it
                pos = 0;
                while (pos < shadow_count && shadow_keys[pos] <= key) pos++;
                for (int i = shadow_count; i > pos; i--) begin
                    shadow_keys[i] = shadow_keys[i-1];
                    shadow_pays[i] = shadow_pays[i-1];
                end
                shadow_keys[pos] = key;
                shadow_pays[pos] = pay;
                shadow_count++;
                ans.status = ST_INSERTED;
            end
        end else if (int'(idx) < shadow_count) begin
            ans.status  = ST_READ_OK;
            ans.key     = shadow_keys[idx];
            ans.payload = shadow_pays[idx];
        end else begin
            ans.status = ST_SLOT_EMPTY;
        end
        ans.entries = 5'(shadow_count);
        return ans;
    endfunction

    // insert keys lean on what is stored so equal and adjacent keys come up often
    function automatic logic [63:0] pick_insert_key();
        logic [63:0] k;
        int slot;
        k = {$urandom, $urandom};
        slot = (shadow_count > 0) ? $urandom_range(shadow_count - 1) : 0;
        case ($urandom_range(9))
            0: k[63:56] = 8'h00;
            1, 2: if (shadow_count > 0) k = shadow_keys[slot];
            3: if (shadow_count > 0) k = shadow_keys[slot] + 64'd1;
            4: if (shadow_count > 0) k = shadow_keys[slot] - 64'd1;
            5: k = ($urandom_range(1) == 1) ? '1 : 64'h0100_0000_0000_0000;
            default: ;
        endcase
        return k;
    endfunction

    // offer one item, idling first at random, and record its answer on acceptance
    task automatic send_item(input sti_cmd_t cmd, input logic [63:0] key,
                             input logic [31:0] pay, input logic [3:0] idx);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {4'b0000, idx, pay, key};
        do @(posedge aclk); while (!s_tready);
        answers_due.push_back(predict_table_item(cmd, key, pay, idx));
    endtask

    // sender goes quiet until every outstanding answer has come back
    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (answers_due.size() != 0);
    endtask

    task automatic test_empty_table_reads();
        send_item(CMD_READ, '0, '0, 4'd0);
        send_item(CMD_READ, '1, '1, 4'd15);
    endtask

    task automatic test_refused_keys();
        send_item(CMD_INSERT, 64'h0, 32'h1234_5678, 4'd0);
        send_item(CMD_INSERT, 64'h00FF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 4'd15);
        send_item(CMD_READ, '0, '0, 4'd0);
    endtask

    // extremes, a key in between, and equal keys that must keep arrival order
    task automatic test_sorted_insert();
        send_item(CMD_INSERT, 64'h8000_0000_0000_0000, 32'h0000_0001, 4'd0);
        send_item(CMD_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 4'd15);
        send_item(CMD_INSERT, 64'h0100_0000_0000_0000, 32'h0000_0000, 4'd0);
        send_item(CMD_INSERT, 64'h8000_0000_0000_0000, 32'h0000_0002, 4'd0);
        send_item(CMD_INSERT, 64'h8000_0000_0000_0000, 32'h0000_0003, 4'd0);
        send_item(CMD_INSERT, 64'h7FFF_FFFF_FFFF_FFFF, 32'hA5A5_5A5A, 4'd0);
        for (int i = 0; i < 7; i++) send_item(CMD_READ, '0, '0, 4'(i));
    endtask

    // a full table refuses every insert, an empty key included
    task automatic test_full_table();
        logic [63:0] k;
        while (shadow_count < DEPTH) begin
            k = pick_insert_key();
            if (k[63:56] == 8'h00) k[63:56] = 8'h41;
            send_item(CMD_INSERT, k, $urandom, 4'($urandom_range(15)));
        end
        send_item(CMD_INSERT, 64'h4242_4242_0000_0000, 32'h5555_AAAA, 4'd0);
        send_item(CMD_INSERT, 64'h0000_0000_0000_0001, 32'hAAAA_5555, 4'd0);
        send_item(CMD_READ, '0, '0, 4'd15);
        send_item(CMD_READ, '0, '0, 4'd0);
        wait_results_drained();
    endtask

    // receiver holds off long enough for the block to stall its input
    task automatic test_back_pressure();
        tx_idle_pct    = 0;
        rx_idle_pct    = 0;
        rx_hold_cycles = 80;
        repeat (30) begin
            send_item(($urandom_range(3) == 0) ? CMD_INSERT : CMD_READ,
                      pick_insert_key(), $urandom, 4'($urandom_range(15)));
        end
        wait_results_drained();
    endtask

    task automatic run_random_traffic(input int n_items, input int tx_pct, input int rx_pct);
        sti_cmd_t cmd;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        repeat (n_items) begin
            cmd = ($urandom_range(99) < 35) ? CMD_INSERT : CMD_READ;
            send_item(cmd, (cmd == CMD_INSERT) ? pick_insert_key() : {$urandom, $urandom},
                      $urandom, 4'($urandom_range(15)));
        end
        wait_results_drained();
    endtask

    // compare one accepted result item with the oldest expectation
    task automatic check_table_answer();
        table_answer_t want;
        if (answers_due.size() == 0) begin
            $error("result item with nothing outstanding: status %0d key %h",
                   m_tuser, m_tdata[63:0]);
            err_count++;
        end else begin
            want = answers_due.pop_front();
            if (m_tuser !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, m_tuser);
                err_count++;
            end
            if (m_tdata[63:0] !== want.key) begin
                $error("out_key: expected %h, got %h", want.key, m_tdata[63:0]);
                err_count++;
            end
            if (m_tdata[95:64] !== want.payload) begin
                $error("out_payload: expected %h, got %h", want.payload, m_tdata[95:64]);
                err_count++;
            end
            if (m_tdata[100:96] !== want.entries) begin
                $error("entry_count: expected %0d, got %0d", want.entries, m_tdata[100:96]);
                err_count++;
            end
        end
    endtask

    // receiver: check on each handshake, then pick next cycle's ready
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) check_table_answer();
        m_tready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end

    // long receiver hold-off, counted down in cycles
    initial begin
        forever begin
            @(posedge aclk);
            if (rx_hold_cycles > 0) begin
                rx_hold = 1'b1;
                while (rx_hold_cycles > 0) begin
                    @(posedge aclk);
                    rx_hold_cycles--;
                end
                rx_hold = 1'b0;
            end
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_table_reads();
        test_refused_keys();
        test_sorted_insert();
        wait_results_drained();

        // sender idles lightly, receiver stalls half the time
        run_random_traffic(700, 15, 50);
        test_full_table();
        test_back_pressure();
        // roles swapped, then full rate both ways
        run_random_traffic(700, 50, 15);
        run_random_traffic(550, 0, 0);

        repeat (DRAIN_WAIT) @(posedge aclk);
        if (err_count == 0) begin
            $display("sorted_table_insert_tb passed");
        end else begin
            $display("sorted_table_insert_tb failed");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+src
src/sti_pkg.sv
src/sti_cell.sv
src/sorted_table_insert.sv
tb/sv/sorted_table_insert_tb.sv
